// ----- src/gpakc_pkg.sv -----
`timescale 1ns / 1ps

package gpakc_pkg;

	localparam int unsigned DECRYPT_STEPS = 6;

	typedef enum logic [1:0] {
		REQ_CLEAR   = 2'd0,
		REQ_CLOCK   = 2'd1,
		REQ_DECRYPT = 2'd2,
		REQ_NONE    = 2'd3
	} gpakc_req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_FINISH
	} gpakc_state_t;

	// one engine clock, or a clear of all engine state
	typedef struct packed {
		logic       step;
		logic       clear;
		logic [7:0] data;
	} gpakc_ctl_t;

endpackage

// ----- src/gpakc_engine.sv -----
`timescale 1ns / 1ps

module gpakc_engine (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gpakc_pkg::gpakc_ctl_t ctl,
	output logic [7:0]           out_byte
);
	import gpakc_pkg::*;

	localparam logic [5:0] MOD5 = 6'd31;
	localparam logic [7:0] MOD7 = 8'd127;

	function automatic logic [4:0] eac5(input logic [4:0] a, input logic [4:0] b);
		logic [5:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s > MOD5) begin
			s = s - MOD5;
		end
		return s[4:0];
	endfunction

	function automatic logic [6:0] eac7(input logic [6:0] a, input logic [6:0] b);
		logic [7:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s > MOD7) begin
			s = s - MOD7;
		end
		return s[6:0];
	endfunction

	logic [4:0] r_q [7];
	logic [6:0] s_q [7];
	logic [4:0] t_q [5];
	logic [7:0] out_q;

	logic [4:0] r_d [7];
	logic [6:0] s_d [7];
	logic [4:0] t_d [5];
	logic [7:0] d;
	logic [4:0] ri, ti;
	logic [6:0] si;
	logic [3:0] sel, nib;

	always_comb begin
		d  = ctl.data ^ out_q;
		ri = d[4:0];
		si = {d[3:0], d[7:5]};
		ti = d[7:3];

		r_d[0] = eac5(r_q[3], {r_q[6][3:0], r_q[6][4]});
		r_d[1] = r_q[0];
		r_d[2] = r_q[1];
		r_d[3] = r_q[2] ^ ri;
		r_d[4] = r_q[3];
		r_d[5] = r_q[4];
		r_d[6] = r_q[5];

		s_d[0] = eac7(s_q[5], {s_q[6][5:0], s_q[6][6]});
		s_d[1] = s_q[0];
		s_d[2] = s_q[1];
		s_d[3] = s_q[2];
		s_d[4] = s_q[3];
		s_d[5] = s_q[4] ^ si;
		s_d[6] = s_q[5];

		t_d[0] = eac5(t_q[4], t_q[2]);
		t_d[1] = t_q[0];
		t_d[2] = t_q[1] ^ ti;
		t_d[3] = t_q[2];
		t_d[4] = t_q[3];

		sel = s_d[0][3:0];
		nib = (~sel & (r_d[0][3:0] ^ r_d[4][3:0])) | (sel & (t_d[0][3:0] ^ t_d[3][3:0]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 7; i++) begin
				r_q[i] <= '0;
				s_q[i] <= '0;
			end
			for (int i = 0; i < 5; i++) begin
				t_q[i] <= '0;
			end
			out_q <= '0;
		end else if (ctl.clear) begin
			for (int i = 0; i < 7; i++) begin
				r_q[i] <= '0;
				s_q[i] <= '0;
			end
			for (int i = 0; i < 5; i++) begin
				t_q[i] <= '0;
			end
			out_q <= '0;
		end else if (ctl.step) begin
			r_q   <= r_d;
			s_q   <= s_d;
			t_q   <= t_d;
			out_q <= {out_q[3:0], nib};
		end
	end

	assign out_byte = out_q;

endmodule

// ----- src/gpa_keystream_cipher.sv -----
`timescale 1ns / 1ps
// A request runs N engine steps (N = repeat_count, 6 for decrypt, 0 otherwise);
// then ST_FINISH loads the result and sets out_valid when no output is pending.
// Only ST_IDLE takes a request, so the single engine step unit does one at a time.
// Reset: arst_n clears all engine registers and the sequencer, not the output bytes.

module gpa_keystream_cipher (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] req_type,
	input  logic [7:0] data_in,
	input  logic [2:0] repeat_count,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [7:0] plain_byte
);
	import gpakc_pkg::*;

	gpakc_state_t state_q, state_d;
	gpakc_ctl_t   ctl;
	gpakc_req_t   req;

	logic [2:0] steps_q;
	logic [7:0] data_q;
	logic [7:0] plain_q;
	logic       decrypt_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic [7:0] plain_byte_q;
	logic [7:0] eng_out;
	logic       accept;
	logic       out_load;
	logic [7:0] plain_now;

	assign req       = gpakc_req_t'(req_type);
	assign accept    = in_valid && in_ready;
	assign plain_now = data_in ^ eng_out;

	gpakc_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.out_byte (eng_out)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if ((req == REQ_CLOCK && repeat_count != 3'd0) || req == REQ_DECRYPT) begin
						state_d = ST_STEP;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_STEP: begin
				if (steps_q == 3'd1) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		ctl.step  = (state_q == ST_STEP);
		ctl.clear = accept && (req == REQ_CLEAR);
		ctl.data  = data_q;
		out_load  = (state_q == ST_FINISH) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			steps_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				priority case (req)
					REQ_CLOCK:   steps_q <= repeat_count;
					REQ_DECRYPT: steps_q <= 3'(DECRYPT_STEPS);
					default:     steps_q <= '0;
				endcase
			end else if (ctl.step) begin
				steps_q <= steps_q - 3'd1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			decrypt_q <= (req == REQ_DECRYPT);
			data_q    <= (req == REQ_DECRYPT) ? plain_now : data_in;
			plain_q   <= (req == REQ_DECRYPT) ? plain_now : 8'd0;
		end else if (ctl.step && decrypt_q) begin
			data_q <= 8'd0;
		end
		if (out_load) begin
			out_byte_q   <= eng_out;
			plain_byte_q <= plain_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign plain_byte = plain_byte_q;

endmodule
